// ===== rtl/core/urlpd_pkg.sv =====
// Package with the shared types and character constants of the URL percent decoder.
`timescale 1ns / 1ps

package urlpd_pkg;

    // Character codes that the decoder recognizes or produces.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // Most results that one input item can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_FORM_MODE        = 3'd0,
        REG_SAFE_MODE        = 3'd1,
        REG_DROP_CONTROLS    = 3'd2,
        REG_QUOTE_CLASS_LOW  = 3'd3,
        REG_QUOTE_CLASS_HIGH = 3'd4
    } reg_index_t;

    // Escape progress.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } phase_t;

    typedef struct packed {
        logic         form_mode;
        logic         safe_mode;
        logic         drop_controls;
        logic [127:0] quote_class;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] item;
        logic [1:0]             count;
    } batch_t;

endpackage

// ===== rtl/core/urlpd_cfg.sv =====
// Configuration register file of the URL percent decoder.
`timescale 1ns / 1ps

module urlpd_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [63:0]       wr_data,
    output urlpd_pkg::cfg_t   cfg
);

    logic         form_mode_reg;
    logic         safe_mode_reg;
    logic         drop_controls_reg;
    logic [63:0]  quote_low_reg;
    logic [63:0]  quote_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_mode_reg     <= 1'b0;
            safe_mode_reg     <= 1'b0;
            drop_controls_reg <= 1'b0;
            quote_low_reg     <= '0;
            quote_high_reg    <= '0;
        end
        else if (wr_en)
        begin
            // Indexes beyond the register list are ignored.
            unique case (wr_index)
                urlpd_pkg::REG_FORM_MODE:        form_mode_reg     <= wr_data[0];
                urlpd_pkg::REG_SAFE_MODE:        safe_mode_reg     <= wr_data[0];
                urlpd_pkg::REG_DROP_CONTROLS:    drop_controls_reg <= wr_data[0];
                urlpd_pkg::REG_QUOTE_CLASS_LOW:  quote_low_reg     <= wr_data;
                urlpd_pkg::REG_QUOTE_CLASS_HIGH: quote_high_reg    <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.form_mode     = form_mode_reg;
    assign cfg.safe_mode     = safe_mode_reg;
    assign cfg.drop_controls = drop_controls_reg;
    assign cfg.quote_class   = {quote_high_reg, quote_low_reg};

endmodule

// ===== rtl/core/urlpd_decode.sv =====
// Combinational decode of one input byte into up to three results and the next escape state.
`timescale 1ns / 1ps

module urlpd_decode
(
    input  logic                 [7:0] in_byte,
    input  logic                       end_of_string,
    input  urlpd_pkg::phase_t          phase,
    input  logic                 [7:0] first_digit,
    input  urlpd_pkg::cfg_t            cfg,
    output urlpd_pkg::batch_t          batch,
    output urlpd_pkg::phase_t          phase_next,
    output logic                 [7:0] digit_next
);

    // Returns the digit value in the low nibble, with bit 4 set when the byte is a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                r = {1'b1, b[3:0]};
            end
            else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            begin
                r = {1'b1, b[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

    logic [4:0] hex_in;
    logic [4:0] hex_first;
    logic [7:0] decoded;
    logic       in_class;
    logic       is_control;
    logic       idle_is_pct;
    logic [7:0] idle_char;
    logic [1:0] cnt;
    urlpd_pkg::res_t [urlpd_pkg::MAX_RESULTS-1:0] items;

    assign hex_in     = hex_value(in_byte);
    assign hex_first  = hex_value(first_digit);
    assign decoded    = {hex_first[3:0], hex_in[3:0]};
    assign in_class   = !decoded[7] && cfg.quote_class[decoded[6:0]];
    assign is_control = decoded == urlpd_pkg::CH_NUL || decoded == urlpd_pkg::CH_LF
                        || decoded == urlpd_pkg::CH_CR;

    // Handling of a byte that arrives with no escape pending.
    assign idle_is_pct = in_byte == urlpd_pkg::CH_PERCENT;
    assign idle_char   = (cfg.form_mode && in_byte == urlpd_pkg::CH_PLUS) ?
                         urlpd_pkg::CH_SPACE : in_byte;

    always_comb
    begin
        items      = '0;
        cnt        = 2'd0;
        phase_next = urlpd_pkg::PH_IDLE;
        digit_next = first_digit;

        unique case (phase)
            urlpd_pkg::PH_ONE:
            begin
                if (hex_in[4])
                begin
                    digit_next = in_byte;
                    phase_next = urlpd_pkg::PH_TWO;
                end
                else
                begin
                    items[cnt] = '{urlpd_pkg::CH_PERCENT, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    if (idle_is_pct)
                    begin
                        phase_next = urlpd_pkg::PH_ONE;
                    end
                    else
                    begin
                        items[cnt] = '{idle_char, 1'b1, 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
            end
            urlpd_pkg::PH_TWO:
            begin
                if (!hex_in[4])
                begin
                    // Malformed escape: replay the percent and the first digit.
                    items[cnt] = '{urlpd_pkg::CH_PERCENT, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    items[cnt] = '{first_digit, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    if (idle_is_pct)
                    begin
                        phase_next = urlpd_pkg::PH_ONE;
                    end
                    else
                    begin
                        items[cnt] = '{idle_char, 1'b1, 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                else if (cfg.safe_mode && in_class)
                begin
                    items[cnt] = '{urlpd_pkg::CH_PERCENT, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    items[cnt] = '{first_digit, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    items[cnt] = '{in_byte, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
                else if (!(cfg.drop_controls && is_control))
                begin
                    items[cnt] = '{decoded, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
            default:
            begin
                if (idle_is_pct)
                begin
                    phase_next = urlpd_pkg::PH_ONE;
                end
                else
                begin
                    items[cnt] = '{idle_char, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
        endcase

        if (end_of_string)
        begin
            // Flush a pending escape literally.
            if (phase_next == urlpd_pkg::PH_ONE)
            begin
                items[cnt] = '{urlpd_pkg::CH_PERCENT, 1'b1, 1'b0};
                cnt = cnt + 2'd1;
            end
            else if (phase_next == urlpd_pkg::PH_TWO)
            begin
                items[cnt] = '{urlpd_pkg::CH_PERCENT, 1'b1, 1'b0};
                cnt = cnt + 2'd1;
                items[cnt] = '{digit_next, 1'b1, 1'b0};
                cnt = cnt + 2'd1;
            end
            phase_next = urlpd_pkg::PH_IDLE;
            digit_next = 8'h00;
            if (cnt == 2'd0)
            begin
                items[0] = '{8'h00, 1'b0, 1'b1};
                cnt = 2'd1;
            end
            else
            begin
                items[cnt - 2'd1].last = 1'b1;
            end
        end

        batch.item  = items;
        batch.count = cnt;
    end

endmodule

// ===== rtl/core/urlpd_outbuf.sv =====
// Result buffer that holds the results of one item and hands them out one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module urlpd_outbuf
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  urlpd_pkg::batch_t       batch,
    output logic                    load_ready,
    output logic [1:0]              count,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    urlpd_pkg::res_t [urlpd_pkg::MAX_RESULTS-1:0] items_reg;
    urlpd_pkg::res_t [urlpd_pkg::MAX_RESULTS-1:0] items_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop        = m_tvalid && m_tready;
    // A new item may land once the buffer is empty or its final result leaves now.
    assign load_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);

    always_comb
    begin
        items_next = items_reg;
        count_next = count_reg;
        if (load)
        begin
            items_next = batch.item;
            count_next = batch.count;
        end
        else if (pop)
        begin
            items_next = {urlpd_pkg::res_t'('0), items_reg[urlpd_pkg::MAX_RESULTS-1:1]};
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

    assign count    = count_reg;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = items_reg[0].data;
    assign m_tuser  = items_reg[0].has_byte;
    assign m_tlast  = items_reg[0].last;

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps

// Streaming URL percent decoder. Encoded bytes enter on the slave stream, one
// item per byte with tlast marking the last byte of a string; decoded bytes
// leave on the master stream. A '%' followed by two hex digits becomes the byte
// they spell; a malformed escape gives back the '%' (and the first digit) and
// then treats the offending byte normally. Form mode turns '+' into a space,
// safe mode keeps escapes of quote-class ASCII characters literal, and
// drop-controls mode discards decoded NUL, CR and LF. At the end of a string a
// pending escape is flushed literally and the final result carries tlast; if
// the final input byte yields no byte at all, a bare end mark with tuser low
// and tdata zero is sent. Each input item is decoded in the cycle it is taken
// and its zero to three results are loaded together into a three-entry result
// buffer, from which one result leaves per cycle while the receiver is ready.
// On traffic where every item yields at most one result, the decoder sustains
// one byte per clock while the receiver does not stall; an item with more
// results holds the input back, as the next item is taken only once the
// buffer is down to its final result being delivered. Configuration is written
// through the cfg port (index 0 form_mode, 1 safe_mode, 2 drop_controls, 3 and
// 4 the low and high halves of the 128-bit quote class) while the stream is
// idle; it is always ready, and indexes beyond 4 are ignored.
module url_percent_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast,   // last
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    urlpd_pkg::cfg_t   cfg;
    urlpd_pkg::batch_t batch;
    urlpd_pkg::phase_t phase_reg;
    urlpd_pkg::phase_t phase_next;
    logic [7:0]        digit_reg;
    logic [7:0]        digit_next;
    logic              accept;
    logic [1:0]        buf_count;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    urlpd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    urlpd_decode u_decode
    (
        .in_byte       (s_tdata),
        .end_of_string (s_tlast),
        .phase         (phase_reg),
        .first_digit   (digit_reg),
        .cfg           (cfg),
        .batch         (batch),
        .phase_next    (phase_next),
        .digit_next    (digit_next)
    );

    // Escape state advances only on accepted items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urlpd_pkg::PH_IDLE;
            digit_reg <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

    urlpd_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .batch      (batch),
        .load_ready (s_tready),
        .count      (buf_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    // Input is taken only when the buffer holds at most its final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (buf_count == 2'd0 || buf_count == 2'd1))
        else $error("input ready while result buffer still holds several results");

    // The end of a string leaves no escape pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (phase_reg == urlpd_pkg::PH_IDLE && digit_reg == 8'h00))
        else $error("escape state not cleared after end of string");

    // Every string end produces at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> m_tvalid)
        else $error("end of string produced no result");

    // A result without a byte is only ever the bare end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'h00))
        else $error("empty result that is not a bare end mark");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the URL percent decoder: directed strings, then random traffic.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int PHASES          = 6;
    localparam int DRAIN_CYCLES    = 4;
    localparam int IDLE_PCT        = 18;

    // First register index past the end of the register list.
    localparam logic [2:0] REG_SPARE = 3'd5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_data  = 64'd0;

    url_percent_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Decoder state and settings as the testbench believes them to be.
    logic              form_q     = 1'b0;
    logic              safe_q     = 1'b0;
    logic              drop_q     = 1'b0;
    logic [127:0]      class_q    = '0;
    urlpd_pkg::phase_t esc_phase  = urlpd_pkg::PH_IDLE;
    logic [7:0]        held_digit = 8'h00;

    // Results of the byte just decoded by the predictor.
    urlpd_pkg::res_t step_out [3];
    int              step_cnt;

    // Decoded results still owed by the block, oldest first.
    urlpd_pkg::res_t decoded_due [$];

    int              err_count = 0;
    int              cycles    = 0;
    bit              calm      = 1'b0;
    urlpd_pkg::res_t want;

    // Directed stimulus table.
    typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;
    typedef struct {
        row_kind_t             kind;
        logic [2:0]            idx;
        logic [63:0]           val;
        logic [7:0]            ch;
        bit                    eos;
        int                    n;       // typed-in result count, or -1 to use the predictor
        urlpd_pkg::res_t [2:0] outs;
    } row_t;

    row_t rows [40];
    int   n_rows = 0;

    function automatic urlpd_pkg::res_t res_of(input logic [7:0] d, input bit h,
                                               input bit l);
        urlpd_pkg::res_t r;
        r.data = d;
        r.has_byte = h;
        r.last = l;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input bit eos, input int n = -1,
                                    input urlpd_pkg::res_t r0 = '0,
                                    input urlpd_pkg::res_t r1 = '0,
                                    input urlpd_pkg::res_t r2 = '0);
        rows[n_rows].kind = ROW_BYTE;
        rows[n_rows].ch = ch;
        rows[n_rows].eos = eos;
        rows[n_rows].n = n;
        rows[n_rows].outs[0] = r0;
        rows[n_rows].outs[1] = r1;
        rows[n_rows].outs[2] = r2;
        n_rows++;
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [63:0] val);
        rows[n_rows].kind = ROW_REG;
        rows[n_rows].idx = idx;
        rows[n_rows].val = val;
        n_rows++;
    endfunction

    function automatic int hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        return -1;
    endfunction

    // Hex digit for a nibble; letters come in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        if ($urandom_range(1) == 1) return 8'h41 + 8'(v) - 8'd10;
        return 8'h61 + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] any_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
        return b;
    endfunction

    // Codes that hit the plus, percent, control and quote class corners.
    function automatic logic [7:0] special_code();
        case ($urandom_range(9))
            0: return urlpd_pkg::CH_NUL;
            1: return urlpd_pkg::CH_LF;
            2: return urlpd_pkg::CH_CR;
            3: return urlpd_pkg::CH_PERCENT;
            4: return urlpd_pkg::CH_PLUS;
            5: return urlpd_pkg::CH_SPACE;
            6: return 8'h2F;
            7: return 8'h7F;
            8: return 8'h80;
            default: return 8'h41;
        endcase
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] val);
        case (idx)
            urlpd_pkg::REG_FORM_MODE:        form_q = val[0];
            urlpd_pkg::REG_SAFE_MODE:        safe_q = val[0];
            urlpd_pkg::REG_DROP_CONTROLS:    drop_q = val[0];
            urlpd_pkg::REG_QUOTE_CLASS_LOW:  class_q[63:0] = val;
            urlpd_pkg::REG_QUOTE_CLASS_HIGH: class_q[127:64] = val;
            default: ;
        endcase
    endfunction

    function automatic void put_byte(input logic [7:0] d);
        if (step_cnt < urlpd_pkg::MAX_RESULTS)
        begin
            step_out[step_cnt] = res_of(d, 1'b1, 1'b0);
            step_cnt++;
        end
    endfunction

    // A byte seen with no escape open.
    function automatic void plain_byte(input logic [7:0] b);
        if (form_q && b == urlpd_pkg::CH_PLUS)
            put_byte(urlpd_pkg::CH_SPACE);
        else if (b == urlpd_pkg::CH_PERCENT)
            esc_phase = urlpd_pkg::PH_ONE;
        else
            put_byte(b);
    endfunction

    // Predicts the results of one input item and advances the decoder state.
    function automatic void decode_byte(input logic [7:0] b, input bit eos);
        int         lo;
        logic [7:0] c;
        step_cnt = 0;
        case (esc_phase)
            urlpd_pkg::PH_ONE:
            begin
                if (hex_val(b) >= 0)
                begin
                    held_digit = b;
                    esc_phase = urlpd_pkg::PH_TWO;
                end
                else
                begin
                    esc_phase = urlpd_pkg::PH_IDLE;
                    put_byte(urlpd_pkg::CH_PERCENT);
                    plain_byte(b);
                end
            end
            urlpd_pkg::PH_TWO:
            begin
                lo = hex_val(b);
                esc_phase = urlpd_pkg::PH_IDLE;
                if (lo < 0)
                begin
                    put_byte(urlpd_pkg::CH_PERCENT);
                    put_byte(held_digit);
                    plain_byte(b);
                end
                else
                begin
                    c = 8'((hex_val(held_digit) << 4) | lo);
                    // A literal-kept escape wins over dropping a control code.
                    if (safe_q && !c[7] && class_q[c[6:0]])
                    begin
                        put_byte(urlpd_pkg::CH_PERCENT);
                        put_byte(held_digit);
                        put_byte(b);
                    end
                    else if (!(drop_q && (c == urlpd_pkg::CH_NUL || c == urlpd_pkg::CH_LF
                                          || c == urlpd_pkg::CH_CR)))
                        put_byte(c);
                end
            end
            default:
            begin
                esc_phase = urlpd_pkg::PH_IDLE;
                plain_byte(b);
            end
        endcase
        if (eos)
        begin
            // Flush a half-seen escape literally.
            if (esc_phase == urlpd_pkg::PH_ONE)
                put_byte(urlpd_pkg::CH_PERCENT);
            else if (esc_phase == urlpd_pkg::PH_TWO)
            begin
                put_byte(urlpd_pkg::CH_PERCENT);
                put_byte(held_digit);
            end
            esc_phase = urlpd_pkg::PH_IDLE;
            held_digit = 8'h00;
            // With nothing else to carry it, the end flag goes out as a bare mark.
            if (step_cnt == 0)
            begin
                step_out[0] = res_of(8'h00, 1'b0, 1'b1);
                step_cnt = 1;
            end
            else
                step_out[step_cnt - 1].last = 1'b1;
        end
    endfunction

    // Offers one item, with random gaps, and books its results once it is taken.
    task automatic send_item(input logic [7:0] b, input bit eos, input int n_typed,
                             input urlpd_pkg::res_t [2:0] typed);
        int i;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        do @(posedge clk); while (!s_tready);
        decode_byte(b, eos);
        if (n_typed >= 0)
        begin
            for (i = 0; i < n_typed; i++)
                decoded_due.push_back(typed[i]);
        end
        else
        begin
            for (i = 0; i < step_cnt; i++)
                decoded_due.push_back(step_out[i]);
        end
    endtask

    // Stops the input and waits until every owed result is out and the block is quiet.
    task automatic settle();
        @(negedge clk) s_tvalid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Builds one random string, mostly well-formed escapes and plain bytes,
    // with some broken escapes, and sends it with the end flag on its last byte.
    task automatic send_random_string(output int sent);
        logic [7:0] text [$];
        int         tokens;
        int         r;
        int         k;
        logic [7:0] v;
        bit         closed;
        tokens = $urandom_range(1, 10);
        closed = 1'b0;
        for (k = 0; k < tokens && !closed; k++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                text.push_back(8'($urandom_range(255)));
            else if (r < 70)
            begin
                v = ($urandom_range(99) < 30) ? special_code() : 8'($urandom_range(255));
                text.push_back(urlpd_pkg::CH_PERCENT);
                text.push_back(hex_char(v[7:4]));
                text.push_back(hex_char(v[3:0]));
            end
            else if (r < 78)
                text.push_back(urlpd_pkg::CH_PLUS);
            else if (r < 90)
            begin
                // Escape cut short by a byte that is not a hex digit.
                text.push_back(urlpd_pkg::CH_PERCENT);
                if ($urandom_range(1) == 1)
                    text.push_back(hex_char(4'($urandom_range(15))));
                text.push_back(any_non_hex());
            end
            else
            begin
                // Escape left open at the end of the string.
                text.push_back(urlpd_pkg::CH_PERCENT);
                if ($urandom_range(1) == 1)
                    text.push_back(hex_char(4'($urandom_range(15))));
                closed = 1'b1;
            end
        end
        for (k = 0; k < text.size(); k++)
            send_item(text[k], k == text.size() - 1, -1, '0);
        sent = text.size();
    endtask

    task automatic set_phase_config(input int p);
        bit          f;
        bit          s;
        bit          d;
        logic [63:0] lo;
        logic [63:0] hi;
        f = 1'($urandom_range(1));
        s = 1'($urandom_range(1));
        d = 1'($urandom_range(1));
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        case (p)
            0:
            begin
                f = 1'b0; s = 1'b0; d = 1'b0; lo = '0; hi = '0;
            end
            1:
            begin
                f = 1'b1; s = 1'b1; d = 1'b1; lo = '1; hi = '1;
            end
            2:
            begin
                f = 1'b1; s = 1'b0; d = 1'b1;
            end
            4:
            begin
                f = 1'b0; s = 1'b1; d = 1'b0;
            end
            default: ;
        endcase
        settle();
        write_reg(urlpd_pkg::REG_FORM_MODE, 64'(f));
        write_reg(urlpd_pkg::REG_SAFE_MODE, 64'(s));
        write_reg(urlpd_pkg::REG_DROP_CONTROLS, 64'(d));
        write_reg(urlpd_pkg::REG_QUOTE_CLASS_LOW, lo);
        write_reg(urlpd_pkg::REG_QUOTE_CLASS_HIGH, hi);
        if ($urandom_range(1) == 1)
            write_reg(3'($urandom_range(7, 5)), {$urandom, $urandom});
    endtask

    // The receiver stalls at random except during the calm phase.
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_due.size() == 0)
            begin
                $display("%0t: unexpected result: data %h has_byte %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end
            else
            begin
                want = decoded_due.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.has_byte
                    || m_tlast !== want.last)
                begin
                    $display({"%0t: mismatch: expected data %h has_byte %b last %b,",
                              " got data %h has_byte %b last %b"},
                             $time, want.data, want.has_byte, want.last,
                             m_tdata, m_tuser, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int p;
        int phase_items;
        int n;
        int strings;

        // Default settings after reset: no form, safe or drop handling.
        add_row(8'h61, 1'b0, 1, res_of(8'h61, 1'b1, 1'b0));
        add_row(8'h00, 1'b0, 1, res_of(8'h00, 1'b1, 1'b0));
        add_row(8'hFF, 1'b1, 1, res_of(8'hFF, 1'b1, 1'b1));
        // A lone percent at the end of a string comes back as is.
        add_row(urlpd_pkg::CH_PERCENT, 1'b1, 1, res_of(urlpd_pkg::CH_PERCENT, 1'b1, 1'b1));
        // Percent and one digit flushed at the end.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0, 0);
        add_row(8'h34, 1'b1, 2, res_of(urlpd_pkg::CH_PERCENT, 1'b1, 1'b0),
                res_of(8'h34, 1'b1, 1'b1));
        // Good escape with a lowercase digit.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0, 0);
        add_row(8'h34, 1'b0, 0);
        add_row(8'h61, 1'b0);
        // Plus stays a plus outside form mode.
        add_row(urlpd_pkg::CH_PLUS, 1'b0, 1, res_of(urlpd_pkg::CH_PLUS, 1'b1, 1'b0));
        // Bad first digit.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0);
        add_row(8'h47, 1'b0);
        // Bad second digit that opens a new escape, flushed at the end.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0);
        add_row(8'h32, 1'b0);
        add_row(urlpd_pkg::CH_PERCENT, 1'b1);
        // All modes on; '/' and LF are in the quote class, CR is not.
        add_reg(urlpd_pkg::REG_FORM_MODE, 64'd1);
        add_reg(urlpd_pkg::REG_SAFE_MODE, 64'd1);
        add_reg(urlpd_pkg::REG_DROP_CONTROLS, 64'd1);
        add_reg(urlpd_pkg::REG_QUOTE_CLASS_LOW, 64'h0000_8000_0000_0400);
        add_reg(urlpd_pkg::REG_QUOTE_CLASS_HIGH, 64'h0000_0000_0000_0002);
        add_reg(REG_SPARE, '1);
        add_row(urlpd_pkg::CH_PLUS, 1'b0, 1, res_of(urlpd_pkg::CH_SPACE, 1'b1, 1'b0));
        add_row(urlpd_pkg::CH_PERCENT, 1'b0);
        add_row(8'h32, 1'b0);
        add_row(8'h46, 1'b0);
        // Dropped CR on the last byte leaves a bare end mark.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0, 0);
        add_row(8'h30, 1'b0, 0);
        add_row(8'h44, 1'b1, 1, res_of(8'h00, 1'b0, 1'b1));
        // LF is quote class, so it stays literal although drop mode is on.
        add_row(urlpd_pkg::CH_PERCENT, 1'b0);
        add_row(8'h30, 1'b0);
        add_row(8'h41, 1'b1);

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (i = 0; i < n_rows; i++)
        begin
            if (rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(rows[i].idx, rows[i].val);
            end
            else
                send_item(rows[i].ch, rows[i].eos, rows[i].n, rows[i].outs);
        end

        for (p = 0; p < PHASES; p++)
        begin
            calm = (p == 3);
            set_phase_config(p);
            phase_items = 0;
            strings = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                // Once, let the output run completely dry mid-phase.
                if (p == 2 && strings == 5)
                    settle();
                send_random_string(n);
                phase_items += n;
                strings++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
